### src/sfcs_pkg.sv
`timescale 1ns / 1ps
// Package for the SPI flash command sequencer: result record, opcodes, field codes.
// No dependencies.
package sfcs_pkg;

    localparam int unsigned PageBytesDefault = 256;
    localparam int unsigned AddressBitsDefault = 24;
    localparam int unsigned MaxResults = 6;

    localparam logic [1:0] KIND_SPI   = 2'd0;
    localparam logic [1:0] KIND_HOST  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] REQ_OP    = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_FLASH = 2'd2;

    localparam logic [3:0] OP_DETECT   = 4'd0;
    localparam logic [3:0] OP_UID      = 4'd1;
    localparam logic [3:0] OP_ERASE    = 4'd2;
    localparam logic [3:0] OP_PROGRAM  = 4'd3;
    localparam logic [3:0] OP_READ     = 4'd4;
    localparam logic [3:0] OP_SEC_ERASE = 4'd5;
    localparam logic [3:0] OP_SEC_PROG = 4'd6;
    localparam logic [3:0] OP_SEC_LOCK = 4'd7;
    localparam logic [3:0] OP_SEC_READ = 4'd8;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_BAD_SEC = 2'd1;
    localparam logic [1:0] STS_UNEXP   = 2'd2;

    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_CHIP_ERASE = 8'hC7;
    localparam logic [7:0] CMD_RDSR1     = 8'h05;
    localparam logic [7:0] CMD_PP        = 8'h02;
    localparam logic [7:0] CMD_FAST_READ = 8'h0B;
    localparam logic [7:0] CMD_READ      = 8'h03;
    localparam logic [7:0] CMD_SEC_ERASE = 8'h44;
    localparam logic [7:0] CMD_SEC_PROG  = 8'h42;
    localparam logic [7:0] CMD_RDSR2     = 8'h35;
    localparam logic [7:0] CMD_WRSR      = 8'h01;
    localparam logic [7:0] CMD_SEC_READ  = 8'h48;
    localparam logic [7:0] CMD_RDID      = 8'h9F;
    localparam logic [7:0] CMD_UID       = 8'h4B;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  spi_byte;
        logic        cs_start;
        logic        cs_end;
        logic [24:0] read_count;
        logic [23:0] id_value;
        logic [1:0]  status_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]  count;
        result_t [MaxResults-1:0] res;
    } batch_t;

endpackage

### src/spi_flash_command_sequencer.sv
`timescale 1ns / 1ps
// Top level of the SPI flash command sequencer.
// Depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back.
//
//   channel  | handshake        | content
//   request  | push / full      | req_type, operation, flash_address, byte_count, sec_index, data_byte
//   result   | pop / empty      | out_kind, spi_byte, cs_start, cs_end, read_count, id_value, status_code, last
//   config   | cfg_we           | cfg_data (fast_read)
//
// A request yields a batch of zero to six results.
// An empty batch is not queued; the others leave one result per cycle unless the receiver
// holds off pop, which stalls them.
// Two batches queue between the front and the output register; full rises when both are held.
// Reset clears state and sets fast_read.
module spi_flash_command_sequencer
    import sfcs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PageBytesDefault,
    parameter int unsigned ADDRESS_BITS = AddressBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [3:0]  operation,
    input  logic [23:0] flash_address,
    input  logic [24:0] byte_count,
    input  logic [1:0]  sec_index,
    input  logic [7:0]  data_byte,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  out_kind,
    output logic [7:0]  spi_byte,
    output logic        cs_start,
    output logic        cs_end,
    output logic [24:0] read_count,
    output logic [23:0] id_value,
    output logic [1:0]  status_code,
    output logic        last
);

    logic    fast_read_reg;
    logic    take, wr, qrd, qempty;
    batch_t  batch, qdata;
    result_t res;

    assign take = push && !full;
    assign wr   = take && (batch.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fast_read_reg <= 1'b1;
        else if (cfg_we)
            fast_read_reg <= cfg_data;
    end

    sfcs_front #(.PAGE_BYTES(PAGE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .fast_read(fast_read_reg), .take(take),
        .req_type(req_type), .operation(operation), .flash_address(flash_address),
        .byte_count(byte_count), .sec_index(sec_index), .data_byte(data_byte),
        .batch(batch)
    );

    sfcs_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr(wr), .wdata(batch), .qfull(full),
        .rd(qrd), .qempty(qempty), .rdata(qdata)
    );

    sfcs_back u_back
    (
        .clk(clk), .rst_n(rst_n), .qempty(qempty), .qdata(qdata), .qrd(qrd),
        .pop(pop), .empty(empty), .res(res)
    );

    assign out_kind    = res.out_kind;
    assign spi_byte    = res.spi_byte;
    assign cs_start    = res.cs_start;
    assign cs_end      = res.cs_end;
    assign read_count  = res.read_count;
    assign id_value    = res.id_value;
    assign status_code = res.status_code;
    assign last        = res.last;

endmodule

### src/sfcs_front.sv
`timescale 1ns / 1ps
// Front: accepts items, tracks the sequencer state and builds the batch of results.
// Depends on sfcs_pkg.
module sfcs_front
    import sfcs_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PageBytesDefault,
    parameter int unsigned ADDRESS_BITS = AddressBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fast_read,
    input  logic        take,
    input  logic [1:0]  req_type,
    input  logic [3:0]  operation,
    input  logic [23:0] flash_address,
    input  logic [24:0] byte_count,
    input  logic [1:0]  sec_index,
    input  logic [7:0]  data_byte,
    output batch_t      batch
);

    localparam int unsigned PageBits = $clog2(PAGE_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE, PH_DETECT, PH_UID, PH_POLL, PH_PDATA, PH_READ, PH_SDATA, PH_STS1, PH_STS2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [3:0]              op_reg, op_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [24:0]             left_reg, left_next;
    logic [7:0]              sts1_reg, sts1_next;
    logic [23:0]             id_reg, id_next;
    logic [3:0]              rcnt_reg, rcnt_next;
    logic [1:0]              lock_reg, lock_next;

    logic [ADDRESS_BITS-1:0] in_addr, addr_inc;
    logic [23:0]             a24, na24;
    logic [24:0]             left_dec;
    logic [7:0]              sec_hi;
    logic                    fin;
    batch_t                  b;

    function automatic result_t spi(logic [7:0] v, logic cs, logic ce, logic [24:0] rc);
        result_t r;
        r = '0;
        r.out_kind = KIND_SPI;
        r.spi_byte = v;
        r.cs_start = cs;
        r.cs_end = ce;
        r.read_count = rc;
        return r;
    endfunction

    function automatic result_t kind_only(logic [1:0] k, logic [23:0] id, logic [1:0] st);
        result_t r;
        r = '0;
        r.out_kind = k;
        r.id_value = id;
        r.status_code = st;
        return r;
    endfunction

    assign in_addr  = flash_address[ADDRESS_BITS-1:0];
    assign a24      = 24'(in_addr);
    assign na24     = 24'(addr_reg);
    assign addr_inc = addr_reg + 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign sec_hi   = {2'b00, sec_index + 2'd1, 4'h0};

    always_comb
    begin
        phase_next = phase_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        sts1_next = sts1_reg;
        id_next = id_reg;
        rcnt_next = rcnt_reg;
        lock_next = lock_reg;
        b = '0;
        fin = 1'b0;
        if (req_type == REQ_OP && phase_reg == PH_IDLE && operation <= OP_SEC_READ)
        begin
            if (operation >= OP_SEC_ERASE && (sec_index == 2'd3 ||
                (operation == OP_SEC_PROG && byte_count > 25'd256)))
            begin
                b.res[0] = kind_only(KIND_ERROR, '0, STS_BAD_SEC);
                b.count = 3'd1;
            end
            else
            begin
                op_next = operation;
                case (operation)
                    OP_DETECT:
                    begin
                        b.res[0] = spi(CMD_RDID, 1'b1, 1'b1, 25'd3);
                        b.count = 3'd1;
                        id_next = '0;
                        rcnt_next = '0;
                        phase_next = PH_DETECT;
                    end
                    OP_UID:
                    begin
                        b.res[0] = spi(CMD_UID, 1'b1, 1'b0, '0);
                        b.res[1] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[2] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[3] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[4] = spi(8'h00, 1'b0, 1'b1, 25'd8);
                        b.count = 3'd5;
                        rcnt_next = '0;
                        phase_next = PH_UID;
                    end
                    OP_ERASE:
                    begin
                        b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
                        b.res[1] = spi(CMD_CHIP_ERASE, 1'b1, 1'b1, '0);
                        b.res[2] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                        b.count = 3'd3;
                        phase_next = PH_POLL;
                    end
                    OP_PROGRAM:
                    begin
                        addr_next = in_addr;
                        left_next = byte_count;
                        fin = (byte_count == '0);
                        b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
                        b.res[1] = spi(CMD_PP, 1'b1, 1'b0, '0);
                        b.res[2] = spi(a24[23:16], 1'b0, 1'b0, '0);
                        b.res[3] = spi(a24[15:8], 1'b0, 1'b0, '0);
                        b.res[4] = spi(a24[7:0], 1'b0, fin, '0);
                        b.res[5] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                        b.count = fin ? 3'd6 : 3'd5;
                        phase_next = fin ? PH_POLL : PH_PDATA;
                    end
                    OP_READ:
                    begin
                        b.res[0] = spi(fast_read ? CMD_FAST_READ : CMD_READ, 1'b1, 1'b0, '0);
                        b.res[1] = spi(a24[23:16], 1'b0, 1'b0, '0);
                        b.res[2] = spi(a24[15:8], 1'b0, 1'b0, '0);
                        if (fast_read)
                        begin
                            b.res[3] = spi(a24[7:0], 1'b0, 1'b0, '0);
                            b.res[4] = spi(8'h00, 1'b0, 1'b1, byte_count);
                        end
                        else
                        begin
                            b.res[3] = spi(a24[7:0], 1'b0, 1'b1, byte_count);
                        end
                        left_next = byte_count;
                        b.count = fast_read ? 3'd5 : 3'd4;
                        if (byte_count == '0)
                        begin
                            b.res[b.count] = kind_only(KIND_DONE, '0, STS_OK);
                            b.count = b.count + 3'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_READ;
                        end
                    end
                    OP_SEC_ERASE:
                    begin
                        b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
                        b.res[1] = spi(CMD_SEC_ERASE, 1'b1, 1'b0, '0);
                        b.res[2] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[3] = spi(sec_hi, 1'b0, 1'b0, '0);
                        b.res[4] = spi(8'h00, 1'b0, 1'b1, '0);
                        b.res[5] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                        b.count = 3'd6;
                        phase_next = PH_POLL;
                    end
                    OP_SEC_PROG:
                    begin
                        fin = (byte_count == '0);
                        left_next = byte_count;
                        b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
                        b.res[1] = spi(CMD_SEC_PROG, 1'b1, 1'b0, '0);
                        b.res[2] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[3] = spi(sec_hi, 1'b0, 1'b0, '0);
                        b.res[4] = spi(flash_address[7:0], 1'b0, fin, '0);
                        b.res[5] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                        b.count = fin ? 3'd6 : 3'd5;
                        phase_next = fin ? PH_POLL : PH_SDATA;
                    end
                    OP_SEC_LOCK:
                    begin
                        lock_next = sec_index;
                        b.res[0] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                        b.count = 3'd1;
                        phase_next = PH_STS1;
                    end
                    default:
                    begin
                        left_next = byte_count;
                        b.res[0] = spi(CMD_SEC_READ, 1'b1, 1'b0, '0);
                        b.res[1] = spi(8'h00, 1'b0, 1'b0, '0);
                        b.res[2] = spi(sec_hi, 1'b0, 1'b0, '0);
                        b.res[3] = spi(flash_address[7:0], 1'b0, 1'b1, byte_count);
                        b.count = 3'd4;
                        if (byte_count == '0)
                        begin
                            b.res[4] = kind_only(KIND_DONE, '0, STS_OK);
                            b.count = 3'd5;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_READ;
                        end
                    end
                endcase
            end
        end
        else if (req_type == REQ_DATA && phase_reg == PH_PDATA)
        begin
            addr_next = addr_inc;
            left_next = left_dec;
            fin = (left_dec == '0) || (addr_inc[PageBits-1:0] == '0);
            b.res[0] = spi(data_byte, 1'b0, fin, '0);
            b.res[1] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
            b.count = fin ? 3'd2 : 3'd1;
            if (fin)
                phase_next = PH_POLL;
        end
        else if (req_type == REQ_DATA && phase_reg == PH_SDATA)
        begin
            left_next = left_dec;
            fin = (left_dec == '0);
            b.res[0] = spi(data_byte, 1'b0, fin, '0);
            b.res[1] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
            b.count = fin ? 3'd2 : 3'd1;
            if (fin)
                phase_next = PH_POLL;
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_DETECT)
        begin
            id_next = {id_reg[15:0], data_byte};
            rcnt_next = rcnt_reg + 4'd1;
            if (rcnt_reg >= 4'd2)
            begin
                b.res[0] = kind_only(KIND_DONE, {id_reg[15:0], data_byte}, STS_OK);
                b.count = 3'd1;
                phase_next = PH_IDLE;
            end
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_UID)
        begin
            b.res[0] = '0;
            b.res[0].out_kind = KIND_HOST;
            b.res[0].spi_byte = data_byte;
            b.res[1] = kind_only(KIND_DONE, '0, STS_OK);
            rcnt_next = rcnt_reg + 4'd1;
            b.count = (rcnt_reg >= 4'd7) ? 3'd2 : 3'd1;
            if (rcnt_reg >= 4'd7)
                phase_next = PH_IDLE;
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_READ)
        begin
            b.res[0] = '0;
            b.res[0].out_kind = KIND_HOST;
            b.res[0].spi_byte = data_byte;
            b.res[1] = kind_only(KIND_DONE, '0, STS_OK);
            left_next = left_dec;
            b.count = (left_dec == '0) ? 3'd2 : 3'd1;
            if (left_dec == '0)
                phase_next = PH_IDLE;
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_POLL)
        begin
            if (data_byte[0])
            begin
                b.res[0] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
                b.count = 3'd1;
            end
            else if (op_reg == OP_PROGRAM && left_reg != '0)
            begin
                b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
                b.res[1] = spi(CMD_PP, 1'b1, 1'b0, '0);
                b.res[2] = spi(na24[23:16], 1'b0, 1'b0, '0);
                b.res[3] = spi(na24[15:8], 1'b0, 1'b0, '0);
                b.res[4] = spi(na24[7:0], 1'b0, 1'b0, '0);
                b.count = 3'd5;
                phase_next = PH_PDATA;
            end
            else
            begin
                b.res[0] = kind_only(KIND_DONE, '0, STS_OK);
                b.count = 3'd1;
                phase_next = PH_IDLE;
            end
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_STS1)
        begin
            sts1_next = data_byte;
            b.res[0] = spi(CMD_RDSR2, 1'b1, 1'b1, 25'd1);
            b.count = 3'd1;
            phase_next = PH_STS2;
        end
        else if (req_type == REQ_FLASH && phase_reg == PH_STS2)
        begin
            b.res[0] = spi(CMD_WREN, 1'b1, 1'b1, '0);
            b.res[1] = spi(CMD_WRSR, 1'b1, 1'b0, '0);
            b.res[2] = spi(sts1_reg, 1'b0, 1'b0, '0);
            b.res[3] = spi(data_byte | (8'h08 << lock_reg), 1'b0, 1'b1, '0);
            b.res[4] = spi(CMD_RDSR1, 1'b1, 1'b1, 25'd1);
            b.count = 3'd5;
            phase_next = PH_POLL;
        end
        else
        begin
            b.res[0] = kind_only(KIND_ERROR, '0, STS_UNEXP);
            b.count = 3'd1;
        end
        for (int i = 0; i < MaxResults; i++)
            b.res[i].last = (3'(i + 1) == b.count);
    end

    assign batch = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg <= '0;
            addr_reg <= '0;
            left_reg <= '0;
            sts1_reg <= '0;
            id_reg <= '0;
            rcnt_reg <= '0;
            lock_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            op_reg <= op_next;
            addr_reg <= addr_next;
            left_reg <= left_next;
            sts1_reg <= sts1_next;
            id_reg <= id_next;
            rcnt_reg <= rcnt_next;
            lock_reg <= lock_next;
        end
    end

endmodule

### src/sfcs_queue.sv
`timescale 1ns / 1ps
// Batch queue between front and back.
// Depends on sfcs_pkg.
module sfcs_queue
    import sfcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  batch_t wdata,
    output logic   qfull,
    input  logic   rd,
    output logic   qempty,
    output batch_t rdata
);

    batch_t     mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign qfull  = cnt_reg == 2'd2;
    assign qempty = cnt_reg == 2'd0;
    assign rdata  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

### src/sfcs_back.sv
`timescale 1ns / 1ps
// Back: walks one batch result by result onto the output register.
// Depends on sfcs_pkg.
module sfcs_back
    import sfcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    qempty,
    input  batch_t  qdata,
    output logic    qrd,
    input  logic    pop,
    output logic    empty,
    output result_t res
);

    logic [2:0] idx_reg;
    logic       full_reg;
    result_t    res_reg;
    logic       load;
    logic       done_batch;

    assign load       = !qempty && (!full_reg || pop);
    assign done_batch = (idx_reg + 3'd1) >= qdata.count;
    assign qrd        = load && done_batch;
    assign empty      = !full_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                full_reg <= 1'b1;
                idx_reg <= done_batch ? 3'd0 : idx_reg + 3'd1;
            end
            else if (pop)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= qdata.res[idx_reg];
    end

endmodule

### test/spi_flash_command_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spi_flash_command_sequencer.
// Depends on sfcs_pkg and the sequencer RTL; queue-style request/result ports, random idling.
module spi_flash_command_sequencer_tb;
    import sfcs_pkg::*;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_DETECT, SQ_UID, SQ_POLL, SQ_PDATA, SQ_READ, SQ_SDATA, SQ_STS1, SQ_STS2
    } sq_phase_e;

    typedef struct packed {
        logic [1:0]  rt;
        logic [3:0]  op;
        logic [23:0] addr;
        logic [24:0] cnt;
        logic [1:0]  idx;
        logic [7:0]  data;
    } flash_req_t;

    typedef struct {
        sq_phase_e   phase;
        logic [3:0]  op;
        logic [23:0] addr;
        logic [24:0] left;
        logic [7:0]  sts1;
        logic [23:0] idacc;
        logic [3:0]  nrep;
        logic [1:0]  lidx;
        logic        fast;
    } seq_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_data = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = '0;
    logic [3:0]  operation = '0;
    logic [23:0] flash_address = '0;
    logic [24:0] byte_count = '0;
    logic [1:0]  sec_index = '0;
    logic [7:0]  data_byte = '0;
    logic        pop = 1'b0;
    logic        empty;
    logic [1:0]  out_kind;
    logic [7:0]  spi_byte;
    logic        cs_start;
    logic        cs_end;
    logic [24:0] read_count;
    logic [23:0] id_value;
    logic [1:0]  status_code;
    logic        last;

    spi_flash_command_sequencer DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .push(push), .full(full), .req_type(req_type), .operation(operation),
        .flash_address(flash_address), .byte_count(byte_count), .sec_index(sec_index),
        .data_byte(data_byte), .pop(pop), .empty(empty), .out_kind(out_kind),
        .spi_byte(spi_byte), .cs_start(cs_start), .cs_end(cs_end), .read_count(read_count),
        .id_value(id_value), .status_code(status_code), .last(last)
    );

    always #2 clk = ~clk;

    flash_req_t  pending_reqs[$];
    result_t     expected_results[$];
    seq_state_t  dut_shadow;
    seq_state_t  gen_shadow;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          reqs_queued = 0;
    int          reqs_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    logic        taken = 1'b0;

    function automatic void emit(ref result_t r[$], input logic [1:0] k, input logic [7:0] b,
                                 input logic cs, input logic ce, input logic [24:0] rc,
                                 input logic [23:0] id, input logic [1:0] st);
        result_t e;
        e = '{k, b, cs, ce, rc, id, st, 1'b0};
        r.push_back(e);
    endfunction

    function automatic void status_poll(ref seq_state_t s, ref result_t r[$]);
        emit(r, KIND_SPI, CMD_RDSR1, 1, 1, 25'd1, 0, STS_OK);
        s.phase = SQ_POLL;
    endfunction

    function automatic void op_done(ref seq_state_t s, ref result_t r[$], input logic [23:0] id);
        emit(r, KIND_DONE, 0, 0, 0, 0, id, STS_OK);
        s.phase = SQ_IDLE;
    endfunction

    function automatic void page_header(ref seq_state_t s, ref result_t r[$]);
        logic fin;
        fin = (s.left == 0);
        emit(r, KIND_SPI, CMD_WREN, 1, 1, 0, 0, STS_OK);
        emit(r, KIND_SPI, CMD_PP, 1, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, s.addr[23:16], 0, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, s.addr[15:8], 0, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, s.addr[7:0], 0, fin, 0, 0, STS_OK);
        if (fin)
            status_poll(s, r);
        else
            s.phase = SQ_PDATA;
    endfunction

    function automatic void sec_header(ref result_t r[$], input logic [7:0] opc,
                                       input logic [1:0] idx, input logic [7:0] lo,
                                       input logic fin, input logic [24:0] rc);
        logic [7:0] sel;
        sel = ({6'b0, idx} + 8'd1) << 4;
        emit(r, KIND_SPI, opc, 1, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, 8'h00, 0, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, sel, 0, 0, 0, 0, STS_OK);
        emit(r, KIND_SPI, lo, 0, fin, fin ? rc : 25'd0, 0, STS_OK);
    endfunction

    function automatic void start_command(ref seq_state_t s, input flash_req_t q,
                                          ref result_t r[$]);
        if (q.op >= OP_SEC_ERASE && (q.idx > 2 || (q.op == OP_SEC_PROG && q.cnt > 256))) begin
            emit(r, KIND_ERROR, 0, 0, 0, 0, 0, STS_BAD_SEC);
            return;
        end
        s.op = q.op;
        case (q.op)
            OP_DETECT:
            begin
                emit(r, KIND_SPI, CMD_RDID, 1, 1, 25'd3, 0, STS_OK);
                s.idacc = 0;
                s.nrep = 0;
                s.phase = SQ_DETECT;
            end
            OP_UID:
            begin
                emit(r, KIND_SPI, CMD_UID, 1, 0, 0, 0, STS_OK);
                repeat (3) emit(r, KIND_SPI, 0, 0, 0, 0, 0, STS_OK);
                emit(r, KIND_SPI, 0, 0, 1, 25'd8, 0, STS_OK);
                s.nrep = 0;
                s.phase = SQ_UID;
            end
            OP_ERASE:
            begin
                emit(r, KIND_SPI, CMD_WREN, 1, 1, 0, 0, STS_OK);
                emit(r, KIND_SPI, CMD_CHIP_ERASE, 1, 1, 0, 0, STS_OK);
                status_poll(s, r);
            end
            OP_PROGRAM:
            begin
                s.addr = q.addr;
                s.left = q.cnt;
                page_header(s, r);
            end
            OP_READ:
            begin
                emit(r, KIND_SPI, s.fast ? CMD_FAST_READ : CMD_READ, 1, 0, 0, 0, STS_OK);
                emit(r, KIND_SPI, q.addr[23:16], 0, 0, 0, 0, STS_OK);
                emit(r, KIND_SPI, q.addr[15:8], 0, 0, 0, 0, STS_OK);
                if (s.fast) begin
                    emit(r, KIND_SPI, q.addr[7:0], 0, 0, 0, 0, STS_OK);
                    emit(r, KIND_SPI, 8'h00, 0, 1, q.cnt, 0, STS_OK);
                end else begin
                    emit(r, KIND_SPI, q.addr[7:0], 0, 1, q.cnt, 0, STS_OK);
                end
                s.left = q.cnt;
                if (q.cnt == 0)
                    op_done(s, r, 0);
                else
                    s.phase = SQ_READ;
            end
            OP_SEC_ERASE:
            begin
                emit(r, KIND_SPI, CMD_WREN, 1, 1, 0, 0, STS_OK);
                sec_header(r, CMD_SEC_ERASE, q.idx, 8'h00, 1, 0);
                status_poll(s, r);
            end
            OP_SEC_PROG:
            begin
                emit(r, KIND_SPI, CMD_WREN, 1, 1, 0, 0, STS_OK);
                s.left = q.cnt;
                sec_header(r, CMD_SEC_PROG, q.idx, q.addr[7:0], q.cnt == 0, 0);
                if (q.cnt == 0)
                    status_poll(s, r);
                else
                    s.phase = SQ_SDATA;
            end
            OP_SEC_LOCK:
            begin
                s.lidx = q.idx;
                emit(r, KIND_SPI, CMD_RDSR1, 1, 1, 25'd1, 0, STS_OK);
                s.phase = SQ_STS1;
            end
            default:
            begin
                s.left = q.cnt;
                sec_header(r, CMD_SEC_READ, q.idx, q.addr[7:0], 1, q.cnt);
                if (q.cnt == 0)
                    op_done(s, r, 0);
                else
                    s.phase = SQ_READ;
            end
        endcase
    endfunction

    function automatic void sequencer_step(ref seq_state_t s, input flash_req_t q,
                                           ref result_t r[$]);
        logic fin;
        r.delete();
        if (q.rt == REQ_OP && s.phase == SQ_IDLE && q.op <= OP_SEC_READ) begin
            start_command(s, q, r);
        end else if (q.rt == REQ_DATA && s.phase == SQ_PDATA) begin
            s.addr = s.addr + 1;
            s.left = s.left - 1;
            fin = (s.left == 0) || (s.addr[7:0] == 0);
            emit(r, KIND_SPI, q.data, 0, fin, 0, 0, STS_OK);
            if (fin)
                status_poll(s, r);
        end else if (q.rt == REQ_DATA && s.phase == SQ_SDATA) begin
            s.left = s.left - 1;
            fin = (s.left == 0);
            emit(r, KIND_SPI, q.data, 0, fin, 0, 0, STS_OK);
            if (fin)
                status_poll(s, r);
        end else if (q.rt == REQ_FLASH && s.phase == SQ_DETECT) begin
            s.idacc = {s.idacc[15:0], q.data};
            s.nrep = s.nrep + 1;
            if (s.nrep >= 3)
                op_done(s, r, s.idacc);
        end else if (q.rt == REQ_FLASH && s.phase == SQ_UID) begin
            emit(r, KIND_HOST, q.data, 0, 0, 0, 0, STS_OK);
            s.nrep = s.nrep + 1;
            if (s.nrep >= 8)
                op_done(s, r, 0);
        end else if (q.rt == REQ_FLASH && s.phase == SQ_READ) begin
            emit(r, KIND_HOST, q.data, 0, 0, 0, 0, STS_OK);
            s.left = s.left - 1;
            if (s.left == 0)
                op_done(s, r, 0);
        end else if (q.rt == REQ_FLASH && s.phase == SQ_POLL) begin
            if (q.data[0])
                status_poll(s, r);
            else if (s.op == OP_PROGRAM && s.left != 0)
                page_header(s, r);
            else
                op_done(s, r, 0);
        end else if (q.rt == REQ_FLASH && s.phase == SQ_STS1) begin
            s.sts1 = q.data;
            emit(r, KIND_SPI, CMD_RDSR2, 1, 1, 25'd1, 0, STS_OK);
            s.phase = SQ_STS2;
        end else if (q.rt == REQ_FLASH && s.phase == SQ_STS2) begin
            emit(r, KIND_SPI, CMD_WREN, 1, 1, 0, 0, STS_OK);
            emit(r, KIND_SPI, CMD_WRSR, 1, 0, 0, 0, STS_OK);
            emit(r, KIND_SPI, s.sts1, 0, 0, 0, 0, STS_OK);
            emit(r, KIND_SPI, q.data | (8'h08 << s.lidx), 0, 1, 0, 0, STS_OK);
            status_poll(s, r);
        end else begin
            emit(r, KIND_ERROR, 0, 0, 0, 0, 0, STS_UNEXP);
        end
        if (r.size() > 0)
            r[r.size()-1].last = 1'b1;
    endfunction

    // Queue a request and advance the generator's view of the sequencer.
    task automatic queue_req(input flash_req_t q);
        result_t scratch[$];
        sequencer_step(gen_shadow, q, scratch);
        pending_reqs.push_back(q);
        reqs_queued++;
    endtask

    task automatic queue_op(input logic [3:0] op, input logic [23:0] adr,
                            input logic [24:0] cnt, input logic [1:0] idx);
        flash_req_t q;
        q = '{REQ_OP, op, adr, cnt, idx, 8'($urandom)};
        queue_req(q);
    endtask

    // Next item that fits the current phase of the operation in progress, or, when noisy, at times a random one.
    task automatic queue_follow(input bit noisy);
        flash_req_t q;
        int         pick;
        q = flash_req_t'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (noisy && pick < 4) begin
            queue_req(q);
            return;
        end
        case (gen_shadow.phase)
            SQ_IDLE:
            begin
                q.rt = REQ_OP;
                q.op = (pick < 6) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
                q.idx = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                if (q.op == OP_PROGRAM) begin
                    q.cnt = $urandom_range(0, 40);
                    if ($urandom_range(0, 1))
                        q.addr[7:0] = 8'($urandom_range(232, 255));
                end else if (q.op == OP_READ || q.op == OP_SEC_READ) begin
                    q.cnt = $urandom_range(0, 6);
                end else if (q.op == OP_SEC_PROG) begin
                    case ($urandom_range(0, 9))
                        0: q.cnt = 25'd256 + 25'($urandom_range(0, 1));
                        1: ;
                        default: q.cnt = $urandom_range(0, 6);
                    endcase
                end
            end
            SQ_PDATA, SQ_SDATA: q.rt = REQ_DATA;
            SQ_POLL:
            begin
                q.rt = REQ_FLASH;
                q.data[0] = ($urandom_range(0, 3) == 0);
            end
            default: q.rt = REQ_FLASH;
        endcase
        queue_req(q);
    endtask

    task automatic finish_op();
        while (gen_shadow.phase != SQ_IDLE)
            queue_follow(1'b0);
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_fast_read(input logic v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_shadow.fast = v;
    endtask

    task automatic run_phase(input int n, input logic fr, input int s_idle, input int r_idle,
                             input bit hold, input bit pause);
        write_fast_read(fr);
        send_idle = s_idle;
        recv_idle = r_idle;
        if (hold)
            hold_req++;
        for (int i = 0; i < n; i++) begin
            queue_follow(1'b1);
            if (pause && i == n / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    // Sender: one item per transfer, random gaps.
    always @(negedge clk) begin
        flash_req_t q;
        if (rst_n && (!push || taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                q = pending_reqs.pop_front();
                req_type <= q.rt;
                operation <= q.op;
                flash_address <= q.addr;
                byte_count <= q.cnt;
                sec_index <= q.idx;
                data_byte <= q.data;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random pops, plus a long hold-off on request.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge clk) begin
        flash_req_t q;
        result_t    r[$];
        result_t    got;
        result_t    want;
        if (rst_n) begin
            taken <= push && !full;
            quiet_cycles++;
            if (cfg_we)
                dut_shadow.fast = cfg_data;
            if (push && !full) begin
                q = '{req_type, operation, flash_address, byte_count, sec_index, data_byte};
                sequencer_step(dut_shadow, q, r);
                foreach (r[i]) expected_results.push_back(r[i]);
                reqs_taken++;
                quiet_cycles = 0;
            end
            if (pop && !empty) begin
                got = '{out_kind, spi_byte, cs_start, cs_end, read_count, id_value,
                        status_code, last};
                quiet_cycles = 0;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: expected %p got %p",
                                     results_seen, want, got);
                    end
                end
            end
            if (quiet_cycles > 5000) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        flash_req_t q;
        dut_shadow = '{SQ_IDLE, 0, 0, 0, 0, 0, 0, 0, 1'b1};
        gen_shadow = dut_shadow;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every operation, error paths, out-of-turn items
        queue_op(OP_DETECT, 24'hFFFFFF, '1, 2'd3);
        finish_op();
        queue_op(OP_UID, 0, 0, 0);
        finish_op();
        queue_op(OP_ERASE, 0, 0, 0);
        finish_op();
        queue_op(OP_PROGRAM, 24'h0000FE, 25'd3, 0);
        finish_op();
        queue_op(OP_PROGRAM, 24'hFFFFFF, 0, 0);
        finish_op();
        queue_op(OP_READ, 24'hABCDEF, 25'd1, 0);
        finish_op();
        queue_op(OP_READ, 0, 0, 0);
        queue_op(OP_SEC_ERASE, 0, 0, 2'd2);
        finish_op();
        queue_op(OP_SEC_PROG, 24'h0000FF, 25'd1, 0);
        finish_op();
        queue_op(OP_SEC_PROG, 0, 25'd257, 0);
        queue_op(OP_SEC_LOCK, 0, 0, 2'd2);
        finish_op();
        queue_op(OP_SEC_READ, 24'h000080, 25'd1, 2'd1);
        finish_op();
        queue_op(OP_SEC_READ, 0, 0, 2'd3);
        queue_op(4'd9, 0, 0, 0);
        queue_op(4'd15, 0, 0, 0);
        q = '{2'd3, 0, 0, 0, 0, 0};
        queue_req(q);
        q = '{REQ_DATA, 0, 0, 0, 0, 8'hFF};
        queue_req(q);
        q = '{REQ_FLASH, 0, 0, 0, 0, 8'h00};
        queue_req(q);
        wait_drained();

        run_phase(120, 1'b0, 13, 55, 1'b0, 1'b1);
        run_phase(120, 1'b1, 55, 13, 1'b1, 1'b0);
        run_phase(120, 1'b0, 0, 0, 1'b0, 1'b0);

        $display("covered %0d requests, %0d results, all operations under both read modes",
                 reqs_taken, results_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/sfcs_pkg.sv
src/sfcs_front.sv
src/sfcs_queue.sv
src/sfcs_back.sv
src/spi_flash_command_sequencer.sv
test/spi_flash_command_sequencer_tb.sv
